// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;

	localparam logic [7:0] ATTR_RESET   = 8'h07;
	localparam logic [7:0] NEWLINE_CODE = 8'h0a;
	localparam logic [7:0] SPACE_CODE   = 8'h20;

	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_SHIFT  = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COLUMN = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_MOVE  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_FILL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		WALK_HOLD,
		WALK_RESTART,
		WALK_STEP
	} walk_op_t;

	typedef struct packed {
		walk_op_t          op;
		logic [ADDR_W-1:0] limit;
	} walk_ctrl_t;

	typedef struct packed {
		logic [ADDR_W-1:0] ptr;
		logic              at_limit;
	} walk_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row);
		return ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
	endfunction

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tcw_walker.sv =====
module tcw_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::walk_ctrl_t ctrl,
	output tcw_pkg::walk_stat_t stat
);

	logic [tcw_pkg::ADDR_W-1:0] ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			case (ctrl.op)
				tcw_pkg::WALK_RESTART: ptr_q <= '0;
				tcw_pkg::WALK_STEP:    ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
				default:               ptr_q <= ptr_q;
			endcase
		end
	end

	assign stat.ptr      = ptr_q;
	assign stat.at_limit = (ptr_q == ctrl.limit);

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console over a COLUMNS x ROWS screen of 16-bit cells (attribute byte
// above character byte) held in one single-port-write, registered-read RAM.
// After reset the block sweeps the RAM to zero, one cell a cycle, with
// in_stall high. A put, move or read then passes through ST_EXEC (and
// ST_READ for a read) and ST_DONE into the output register. A put that
// scrolls walks the RAM through one shared address counter: each moved
// cell is read in ST_SCROLL_RD and written in ST_SCROLL_WR, then each
// blanked cell is written in ST_FILL. A clear writes every cell once.
// One request is taken at a time; a finished result waits in the output
// register while the next request is accepted.
module text_console_writer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [7:0]                cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [7:0]                char_code,
	input  logic [7:0]                target_column,
	input  logic [7:0]                target_row,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               read_data,
	output logic [tcw_pkg::COL_W-1:0] cursor_column,
	output logic [tcw_pkg::ROW_W-1:0] cursor_row,
	output logic                      scrolled
);

	tcw_pkg::state_t state_q, state_d;

	logic [7:0]                 attr_q;
	tcw_pkg::func_t             func_q;
	logic [7:0]                 char_q;
	logic [tcw_pkg::COL_W-1:0]  tcol_q, cur_col_q, out_col_q;
	logic [tcw_pkg::ROW_W-1:0]  trow_q, cur_row_q, out_row_q;
	logic [15:0]                rdata_q, out_rdata_q;
	logic                       scrolled_q, out_scrolled_q, out_valid_q;

	logic                         ram_we;
	logic [tcw_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]   ram_wdata, ram_rdata;
	tcw_pkg::walk_ctrl_t          walk_ctrl;
	tcw_pkg::walk_stat_t          walk_stat;

	logic                       accept, out_free, is_newline, wrap, need_scroll;
	logic [tcw_pkg::COL_W:0]    col_inc;
	logic [tcw_pkg::CELL_W-1:0] blank;
	logic [tcw_pkg::COL_W-1:0]  tcol_clamped;
	logic [tcw_pkg::ROW_W-1:0]  trow_clamped;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != tcw_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign blank       = {attr_q, tcw_pkg::SPACE_CODE};
	assign is_newline  = (char_q == tcw_pkg::NEWLINE_CODE);
	assign col_inc     = {1'b0, cur_col_q} + (tcw_pkg::COL_W+1)'(1);
	assign wrap        = is_newline || (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
	assign need_scroll = wrap && (cur_row_q == tcw_pkg::LAST_ROW);

	assign tcol_clamped = (target_column > 8'(tcw_pkg::LAST_COLUMN)) ?
		tcw_pkg::LAST_COLUMN : tcw_pkg::COL_W'(target_column);
	assign trow_clamped = (target_row > 8'(tcw_pkg::LAST_ROW)) ?
		tcw_pkg::LAST_ROW : tcw_pkg::ROW_W'(target_row);

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tcw_walker u_walker (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (walk_ctrl),
		.stat  (walk_stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (walk_stat.at_limit) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) state_d = tcw_pkg::ST_EXEC;
			end
			tcw_pkg::ST_EXEC: begin
				case (func_q)
					tcw_pkg::FUNC_PUT:   state_d = need_scroll ? tcw_pkg::ST_SCROLL_RD :
						tcw_pkg::ST_DONE;
					tcw_pkg::FUNC_CLEAR: state_d = tcw_pkg::ST_CLEAR;
					tcw_pkg::FUNC_READ:  state_d = tcw_pkg::ST_READ;
					default:             state_d = tcw_pkg::ST_DONE;
				endcase
			end
			tcw_pkg::ST_READ:      state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_SCROLL_RD: state_d = tcw_pkg::ST_SCROLL_WR;
			tcw_pkg::ST_SCROLL_WR: begin
				state_d = walk_stat.at_limit ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCROLL_RD;
			end
			tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
				if (walk_stat.at_limit) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (out_free) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		ram_we          = 1'b0;
		ram_waddr       = walk_stat.ptr;
		ram_wdata       = blank;
		ram_raddr       = walk_stat.ptr + tcw_pkg::ROW_STRIDE;
		walk_ctrl.op    = tcw_pkg::WALK_HOLD;
		walk_ctrl.limit = tcw_pkg::LAST_CELL;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
				walk_ctrl.op = walk_stat.at_limit ? tcw_pkg::WALK_HOLD : tcw_pkg::WALK_STEP;
			end
			tcw_pkg::ST_EXEC: begin
				ram_we       = (func_q == tcw_pkg::FUNC_PUT) && !is_newline;
				ram_waddr    = tcw_pkg::cell_addr(cur_col_q, cur_row_q);
				ram_wdata    = {attr_q, char_q};
				ram_raddr    = tcw_pkg::cell_addr(tcol_q, trow_q);
				walk_ctrl.op = tcw_pkg::WALK_RESTART;
			end
			tcw_pkg::ST_SCROLL_RD: begin
				walk_ctrl.limit = tcw_pkg::LAST_SHIFT;
			end
			tcw_pkg::ST_SCROLL_WR: begin
				ram_we          = 1'b1;
				ram_wdata       = ram_rdata;
				walk_ctrl.op    = tcw_pkg::WALK_STEP;
				walk_ctrl.limit = tcw_pkg::LAST_SHIFT;
			end
			tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR: begin
				ram_we       = 1'b1;
				walk_ctrl.op = walk_stat.at_limit ? tcw_pkg::WALK_HOLD : tcw_pkg::WALK_STEP;
			end
			default: begin
				walk_ctrl.op = tcw_pkg::WALK_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tcw_pkg::ST_INIT;
			attr_q         <= tcw_pkg::ATTR_RESET;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) attr_q <= cfg_wdata;
			if (state_q == tcw_pkg::ST_EXEC) begin
				case (func_q)
					tcw_pkg::FUNC_PUT: begin
						if (wrap) begin
							cur_col_q <= '0;
							if (!need_scroll) cur_row_q <= cur_row_q + tcw_pkg::ROW_W'(1);
						end else begin
							cur_col_q <= col_inc[tcw_pkg::COL_W-1:0];
						end
					end
					tcw_pkg::FUNC_MOVE: begin
						cur_col_q <= tcol_q;
						cur_row_q <= trow_q;
					end
					tcw_pkg::FUNC_CLEAR: begin
						cur_col_q <= '0;
						cur_row_q <= '0;
					end
					default: begin
						cur_col_q <= cur_col_q;
					end
				endcase
			end
			// hold the result until taken, then free the slot
			if (state_q == tcw_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= tcw_pkg::func_t'(func);
			char_q     <= char_code;
			tcol_q     <= tcol_clamped;
			trow_q     <= trow_clamped;
			rdata_q    <= '0;
			scrolled_q <= 1'b0;
		end
		if (state_q == tcw_pkg::ST_EXEC) scrolled_q <= (func_q == tcw_pkg::FUNC_PUT) && need_scroll;
		if (state_q == tcw_pkg::ST_READ) rdata_q <= ram_rdata;
		if (state_q == tcw_pkg::ST_DONE && out_free) begin
			out_rdata_q    <= rdata_q;
			out_col_q      <= cur_col_q;
			out_row_q      <= cur_row_q;
			out_scrolled_q <= scrolled_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = out_rdata_q;
	assign cursor_column = out_col_q;
	assign cursor_row    = out_row_q;
	assign scrolled      = out_scrolled_q;

endmodule

// ===== rtl/tcw_checker.sv =====
module tcw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [15:0]               read_data,
	input logic [tcw_pkg::COL_W-1:0] cursor_column,
	input logic [tcw_pkg::ROW_W-1:0] cursor_row,
	input logic                      scrolled
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_data) && $stable(cursor_column)
			&& $stable(cursor_row) && $stable(scrolled))
		else $error("stalled result changed");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_column <= tcw_pkg::LAST_COLUMN)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_row <= tcw_pkg::LAST_ROW)
		else $error("cursor row out of range");

	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cursor_row == tcw_pkg::LAST_ROW && cursor_column == '0)
		else $error("scroll left cursor off the start of the bottom row");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

// ===== test/console_checker.sv =====
module console_checker
	import tcw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       func,
	input  logic [7:0]       char_code,
	input  logic [7:0]       target_column,
	input  logic [7:0]       target_row,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [15:0]      read_data,
	input  logic [COL_W-1:0] cursor_column,
	input  logic [ROW_W-1:0] cursor_row,
	input  logic             scrolled,
	output int               mismatches,
	output int               outstanding
);

	typedef struct packed {
		logic [15:0]      read_data;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             scrolled;
	} console_result_t;

	logic [15:0]     screen [CELLS];
	logic [7:0]      attr;
	int              cur_col;
	int              cur_row;
	int              errs;
	console_result_t pending_results [$];

	function automatic console_result_t console_step(input func_t f, input logic [7:0] ch,
			input logic [7:0] col_in, input logic [7:0] row_in);
		console_result_t r;
		int col;
		int row;
		logic [15:0] blank;
		col = (col_in > COLUMNS - 1) ? COLUMNS - 1 : int'(col_in);
		row = (row_in > ROWS - 1) ? ROWS - 1 : int'(row_in);
		blank = {attr, SPACE_CODE};
		r = '0;
		case (f)
			FUNC_PUT: begin
				if (ch != NEWLINE_CODE) begin
					screen[cur_row * COLUMNS + cur_col] = {attr, ch};
					cur_col++;
				end
				if (ch == NEWLINE_CODE || cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
					if (cur_row >= ROWS) begin
						// shift every row up by one and blank the bottom row
						cur_row = ROWS - 1;
						for (int i = 0; i < CELLS - COLUMNS; i++)
							screen[i] = screen[i + COLUMNS];
						for (int i = CELLS - COLUMNS; i < CELLS; i++)
							screen[i] = blank;
						r.scrolled = 1'b1;
					end
				end
			end
			FUNC_MOVE: begin
				cur_col = col;
				cur_row = row;
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = blank;
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				r.read_data = screen[row * COLUMNS + col];
			end
		endcase
		r.column = COL_W'(cur_col);
		r.row    = ROW_W'(cur_row);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		console_result_t got;
		console_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = '0;
			cur_col = 0;
			cur_row = 0;
			attr = ATTR_RESET;
			errs = 0;
			pending_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				attr = cfg_wdata;
			if (out_valid && !out_stall) begin
				got = {read_data, cursor_column, cursor_row, scrolled};
				if (pending_results.size() == 0) begin
					$error("result 0x%0h arrived with no request outstanding", got);
					errs++;
				end else begin
					want = pending_results.pop_front();
					check_field("read_data", want.read_data, got.read_data);
					check_field("cursor_column", 16'(want.column), 16'(got.column));
					check_field("cursor_row", 16'(want.row), 16'(got.row));
					check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(console_step(func_t'(func), char_code,
						target_column, target_row));
			outstanding <= pending_results.size();
			mismatches <= errs;
		end
	end

endmodule

// ===== test/tb.sv =====
module tb;
	import tcw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int CHUNKS         = 9;
	localparam int CHUNK_ITEMS    = 150;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_we        = 1'b0;
	logic [7:0]       cfg_wdata     = '0;
	logic             in_valid      = 1'b0;
	logic             in_stall;
	logic [1:0]       func          = '0;
	logic [7:0]       char_code     = '0;
	logic [7:0]       target_column = '0;
	logic [7:0]       target_row    = '0;
	logic             out_valid;
	logic             out_stall     = 1'b0;
	logic [15:0]      read_data;
	logic [COL_W-1:0] cursor_column;
	logic [ROW_W-1:0] cursor_row;
	logic             scrolled;

	int mismatches;
	int outstanding;
	int sent          = 0;
	int idle_cycles   = 0;
	bit quiet         = 1'b0;
	bit pressure_done = 1'b0;

	always #6 clk = ~clk;

	text_console_writer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.char_code     (char_code),
		.target_column (target_column),
		.target_row    (target_row),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.scrolled      (scrolled)
	);

	console_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.char_code     (char_code),
		.target_column (target_column),
		.target_row    (target_row),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.scrolled      (scrolled),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	task automatic send_cmd(input func_t f, input logic [7:0] ch, input logic [7:0] col,
			input logic [7:0] row);
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		char_code     <= ch;
		target_column <= col;
		target_row    <= row;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// drop valid, wait for every result, then let the block settle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int pick;
		logic [7:0] ch;
		logic [7:0] col;
		logic [7:0] row;
		repeat (count) begin
			pick = $urandom_range(99);
			ch   = 8'($urandom_range(255));
			col  = 8'($urandom_range(255));
			row  = 8'($urandom_range(255));
			if (pick < 55) begin
				if ($urandom_range(5) == 0)
					ch = NEWLINE_CODE;
				send_cmd(FUNC_PUT, ch, col, row);
			end else if (pick < 70) begin
				// favour the bottom rows so that puts soon scroll
				if ($urandom_range(1) == 0) begin
					col = 8'($urandom_range(COLUMNS - 1));
					row = 8'($urandom_range(ROWS - 1, ROWS - 3));
				end
				send_cmd(FUNC_MOVE, ch, col, row);
			end else if (pick < 99) begin
				if ($urandom_range(1) == 0) begin
					col = 8'($urandom_range(COLUMNS - 1));
					row = 8'($urandom_range(ROWS - 1));
				end
				send_cmd(FUNC_READ, ch, col, row);
			end else begin
				send_cmd(FUNC_CLEAR, ch, col, row);
			end
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// hold off until the power-up sweep of the screen is done
		@(posedge clk);
		while (in_stall)
			@(posedge clk);

		send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'hff, 8'd255, 8'd255);
		send_cmd(FUNC_PUT, 8'h41, 8'd0, 8'd0);
		send_cmd(FUNC_PUT, 8'h00, 8'd255, 8'd255);
		send_cmd(FUNC_PUT, 8'hff, 8'd0, 8'd0);
		send_cmd(FUNC_PUT, NEWLINE_CODE, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'h00, 8'd1, 8'd0);
		send_cmd(FUNC_MOVE, 8'h00, 8'd255, 8'd255);
		send_cmd(FUNC_PUT, 8'h5a, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'h00, 8'd79, 8'd23);
		send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd24);
		send_cmd(FUNC_MOVE, 8'h00, 8'd79, 8'd3);
		send_cmd(FUNC_PUT, 8'h7e, 8'd0, 8'd0);
		send_cmd(FUNC_MOVE, 8'h00, 8'd200, 8'd24);
		send_cmd(FUNC_PUT, NEWLINE_CODE, 8'd0, 8'd0);
		settle();

		write_attribute(8'hff);
		send_cmd(FUNC_PUT, 8'h80, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd24);
		send_cmd(FUNC_CLEAR, 8'h00, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'h00, 8'd80, 8'd25);
		settle();

		write_attribute(8'h00);
		send_cmd(FUNC_MOVE, 8'h00, 8'd0, 8'd24);
		send_cmd(FUNC_PUT, NEWLINE_CODE, 8'd0, 8'd0);
		send_cmd(FUNC_READ, 8'h00, 8'd79, 8'd24);
		send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd0);
		settle();

		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			if (chunk == 0)
				write_attribute(8'h00);
			else if (chunk == 1)
				write_attribute(8'hff);
			else
				write_attribute(8'($urandom_range(255)));
			quiet = (chunk == 4);
			run_random(CHUNK_ITEMS);
			settle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!pressure_done && sent >= 60) begin
				// long hold-off so the block backs up and stalls its input
				pressure_done = 1'b1;
				hold = 400;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 14);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_walker.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
test/console_checker.sv
test/tb.sv
